/* design/lcft_pkg.sv */
// Package for the LED chaser with fading trail.
// Holds field widths, register indexes, phase codes and shared struct types.
// No dependencies; every other design file imports it.
package lcft_pkg;

    localparam int MAX_PIXELS_DEF = 64;

    localparam int STEP_W  = 16;
    localparam int LEN_W   = 7;
    localparam int LEVEL_W = 8;
    localparam int IDX_W   = 6;
    localparam int PHASE_W = 3;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_PHASES = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STRAND_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 1'd1;

    // Animation phases.
    localparam logic [PHASE_W-1:0] PH_RED     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_GREEN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BLUE    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_YELLOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CYAN    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_MAGENTA = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
    } rgb_t;

    // Result of the step divider: one-cycle done strobe with quotient mod 6
    // and the remainder.
    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   rem;
    } div_res_t;

    // Command to the pixel store: one read and one write port.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        rgb_t             wr_data;
    } store_cmd_t;

    // Halve every channel, rounding down.
    function automatic rgb_t rgb_half(input rgb_t c);
        rgb_t h;
        h.r = {1'b0, c.r[LEVEL_W-1:1]};
        h.g = {1'b0, c.g[LEVEL_W-1:1]};
        h.b = {1'b0, c.b[LEVEL_W-1:1]};
        return h;
    endfunction

endpackage

/* design/lcft_divider.sv */
// Iterative restoring divider for the animation step, one quotient bit a cycle.
// Keeps the quotient reduced modulo 6 as its bits appear, so only the phase
// and the remainder leave the unit. Depends on lcft_pkg.
module lcft_divider
    import lcft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output div_res_t          res
);

    localparam int CNT_W = $clog2(STEP_W);

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [STEP_W-1:0]  quo_reg,   quo_next;
    logic [LEN_W-1:0]   rem_reg,   rem_next;
    logic [LEN_W-1:0]   dvs_reg,   dvs_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic [LEN_W:0]     trial;
    logic               fits;
    logic [LEN_W:0]     trial_sub;
    logic [PHASE_W:0]   ph_dbl;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[STEP_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        trial_sub = fits ? (trial - {1'b0, dvs_reg}) : trial;
        ph_dbl    = {phase_reg, fits};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        phase_next = phase_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(STEP_W - 1);
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            phase_next = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[STEP_W-2:0], 1'b0};
            rem_next = trial_sub[LEN_W-1:0];
            if (ph_dbl >= (PHASE_W+1)'(NUM_PHASES))
                phase_next = PHASE_W'(ph_dbl - (PHASE_W+1)'(NUM_PHASES));
            else
                phase_next = ph_dbl[PHASE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        phase_reg <= phase_next;
    end

    assign res.done  = done_reg;
    assign res.phase = phase_reg;
    assign res.rem   = rem_reg;

endmodule

/* design/lcft_store.sv */
// Pixel store: one synchronous memory of RGB words, one read and one write
// port, registered read data. Per-entry valid bits make unwritten pixels read
// as black right after reset. Depends on lcft_pkg.
module lcft_store
    import lcft_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_cmd_t cmd,
    output rgb_t       rdata
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    rgb_t                  mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] vld_reg;
    rgb_t                  mem_q_reg;
    logic                  hit_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        if (cmd.rd_en)
            mem_q_reg <= mem[cmd.rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            hit_q_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
                vld_reg[cmd.wr_addr[AW-1:0]] <= 1'b1;
            if (cmd.rd_en)
                hit_q_reg <= vld_reg[cmd.rd_addr[AW-1:0]];
        end
    end

    assign rdata = hit_q_reg ? mem_q_reg : '0;

endmodule

/* design/led_chaser_fade_trail.sv */
// LED chaser with fading trail. Each accepted step word is divided by the
// strand length (strand_length, clamped to MAX_PIXELS); the quotient modulo 6
// picks the phase color (red, green, blue, then half-level yellow, cyan,
// magenta, with the odd phases counting the lit position from the far end),
// and the remainder picks the lit pixel. The strand is then swept once from
// pixel 0: the lit pixel takes the phase color, every other pixel in use has
// each channel halved, and each updated pixel is written back and emitted as
// one output word, the final one flagged by last_pixel. An accepted step is
// divided in the bit-serial divider and then sets up the lit pixel; the
// sweep then moves one pixel per cycle while the output is not stalled,
// through the read, modify and write-back of the pixel store and its
// registered read data. A new step is taken only once the previous sweep
// has issued its final word; that word may still wait in the output
// register. With a strand length of zero a step is accepted and produces
// nothing. The store reads as black after reset; no clearing pass is
// needed. Configuration must be written while no step is in progress.
module led_chaser_fade_trail
    import lcft_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 step_valid,
    output logic                 step_stall,
    input  logic [STEP_W-1:0]    step,

    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output logic [IDX_W-1:0]     pixel_index,
    output logic [LEVEL_W-1:0]   red,
    output logic [LEVEL_W-1:0]   green,
    output logic [LEVEL_W-1:0]   blue,
    output logic                 last_pixel
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PIXELS);

    // Configuration registers.
    logic [LEN_W-1:0]   strand_length_reg;
    logic [LEVEL_W-1:0] max_level_reg;

    // Control state.
    logic [1:0]         state_reg, state_next;
    logic [LEN_W-1:0]   len_reg,   len_next;
    logic [LEN_W-1:0]   lit_pos_reg, lit_pos_next;
    rgb_t               lit_color_reg, lit_color_next;
    logic [LEN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pend_reg,  pend_next;
    logic [LEN_W-1:0]   pend_idx_reg, pend_idx_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg,   out_idx_next;
    rgb_t               out_rgb_reg,   out_rgb_next;
    logic               out_last_reg,  out_last_next;

    logic               accept;
    logic [LEN_W-1:0]   len_eff;
    logic [LEVEL_W-1:0] half_level;
    logic               consume;
    logic               issue;
    logic               pend_is_last;
    div_res_t           div_res;
    store_cmd_t         st_cmd;
    rgb_t               st_rdata;
    rgb_t               new_pix;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_length_reg <= LEN_W'(64);
            max_level_reg     <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRAND_LENGTH: strand_length_reg <= cfg_data[LEN_W-1:0];
                REG_MAX_LEVEL:     max_level_reg     <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff    = (strand_length_reg > MAX_LEN) ? MAX_LEN : strand_length_reg;
    assign half_level = {1'b0, max_level_reg[LEVEL_W-1:1]};

    assign step_stall = (state_reg != S_IDLE);
    assign accept     = step_valid && !step_stall;

    lcft_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (len_eff != '0)),
        .dividend (step),
        .divisor  (len_eff),
        .res      (div_res)
    );

    // A read is in flight for pend_idx; it retires when the output register
    // can take a word. The next read is issued in the same cycle, so the
    // sweep moves one pixel per cycle. Within a sweep every pixel is read
    // and written once, always read before written, so no forwarding is
    // needed; the next step cannot read until the divider has run.
    assign consume      = pend_reg && (!out_valid_reg || !pixel_stall);
    assign issue        = (state_reg == S_SWEEP) && (rd_idx_reg < len_reg)
                          && (!pend_reg || consume);
    assign pend_is_last = (pend_idx_reg == (len_reg - 1'b1));

    assign new_pix = (pend_idx_reg == lit_pos_reg) ? lit_color_reg : rgb_half(st_rdata);

    always_comb
    begin
        st_cmd         = '0;
        st_cmd.rd_en   = issue;
        st_cmd.rd_addr = rd_idx_reg[IDX_W-1:0];
        st_cmd.wr_en   = consume;
        st_cmd.wr_addr = pend_idx_reg[IDX_W-1:0];
        st_cmd.wr_data = new_pix;
    end

    lcft_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (st_cmd),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        lit_pos_next   = lit_pos_reg;
        lit_color_next = lit_color_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (len_eff != '0))
                begin
                    len_next   = len_eff;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    // Odd phases run from the far end of the strand.
                    if (div_res.phase[0])
                        lit_pos_next = len_reg - 1'b1 - div_res.rem;
                    else
                        lit_pos_next = div_res.rem;
                    lit_color_next = '0;
                    case (div_res.phase)
                        PH_RED:    lit_color_next.r = max_level_reg;
                        PH_GREEN:  lit_color_next.g = max_level_reg;
                        PH_BLUE:   lit_color_next.b = max_level_reg;
                        PH_YELLOW:
                        begin
                            lit_color_next.r = half_level;
                            lit_color_next.g = half_level;
                        end
                        PH_CYAN:
                        begin
                            lit_color_next.g = half_level;
                            lit_color_next.b = half_level;
                        end
                        default:
                        begin
                            lit_color_next.r = half_level;
                            lit_color_next.b = half_level;
                        end
                    endcase
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                else if (consume)
                    pend_next = 1'b0;
                if (consume && pend_is_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register: loads a finished pixel whenever it is empty or its
    // word is being taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && pixel_stall;
        out_idx_next   = out_idx_reg;
        out_rgb_next   = out_rgb_reg;
        out_last_next  = out_last_reg;
        if (consume)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = pend_idx_reg[IDX_W-1:0];
            out_rgb_next   = new_pix;
            out_last_next  = pend_is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_pos_reg   <= lit_pos_next;
        lit_color_reg <= lit_color_next;
        pend_idx_reg  <= pend_idx_next;
        out_idx_reg   <= out_idx_next;
        out_rgb_reg   <= out_rgb_next;
        out_last_reg  <= out_last_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_index = out_idx_reg;
    assign red         = out_rgb_reg.r;
    assign green       = out_rgb_reg.g;
    assign blue        = out_rgb_reg.b;
    assign last_pixel  = out_last_reg;

    // The divider hands back a reduced phase and a remainder below the length.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (div_res.phase < PHASE_W'(NUM_PHASES)) && (div_res.rem < len_reg))
        else $error("divider result out of range");

    // The divider only finishes while the sweep is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // The store is only written during a sweep, inside the strand in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        st_cmd.wr_en |-> (state_reg == S_SWEEP) && (pend_idx_reg < len_reg))
        else $error("pixel store written outside a sweep");

    // A word loaded into the output register is flagged last exactly when
    // the sweep returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> (out_last_reg == (state_reg == S_IDLE)))
        else $error("last pixel flag out of step with the sweep");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LED chaser with fading trail.
// Drives step words, predicts every pixel word of each sweep, and checks them.
// Depends on lcft_pkg and the led_chaser_fade_trail RTL only.
module tb_top
    import lcft_pkg::*;
();

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    // A zero length step leaves nothing in the queue to wait on, so the quiet
    // time before a register write has to cover a whole sweep on its own.
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 24;
    localparam int RUN_PCT       = 70;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 65;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PLAN_ROWS     = 33;

    // One output word as the checker sees it.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        rgb_t             color;
        logic             last;
    } strand_word_t;

    // One row of the directed plan. A row either writes a register or sends a
    // step word. Where the lit pixel can be read off by hand, its color is
    // typed into the row and replaces the predicted color for that pixel.
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] sel;
        int unsigned          value;
        bit                   typed;
        int unsigned          lit;
        rgb_t                 color;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 step_valid = 1'b0;
    logic                 step_stall;
    logic [STEP_W-1:0]    step = '0;
    logic                 pixel_valid;
    logic                 pixel_stall = 1'b0;
    logic [IDX_W-1:0]     pixel_index;
    logic [LEVEL_W-1:0]   red;
    logic [LEVEL_W-1:0]   green;
    logic [LEVEL_W-1:0]   blue;
    logic                 last_pixel;

    // The testbench's own copy of the registers and of the pixel store.
    logic [LEN_W-1:0]   strand_len;
    logic [LEVEL_W-1:0] full_level;
    rgb_t               strand_mem [MAX_PIXELS_DEF];

    // Pixel words still to come, oldest first.
    strand_word_t pixels_due [$];
    int unsigned  mismatches = 0;

    // Idling control. The main sequence turns steady_mode on for a stretch
    // with no idling at all, and asks the receiver for a long hold-off by
    // bumping holds_asked; the receiver counts the hold-off itself.
    bit          steady_mode = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_taken = 0;
    int unsigned hold_left = 0;

    // Directed part. After reset the strand is 64 pixels at full level 255.
    // The first rows walk through all six phase colors, including the
    // reversed ones and a step of all ones, and a wrap of the phase back to
    // red. Then the level goes to its extremes, the strand shrinks to a
    // single pixel, a zero length swallows steps without any output, and a
    // length above the store size (127 and 65) is clamped to 64. A 63 pixel
    // strand leaves the top pixel untouched, which the final 64 pixel rows
    // bring back into view.
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{1'b0, REG_STRAND_LENGTH,     0, 1'b1,  0, 24'hFF0000},
        '{1'b0, REG_STRAND_LENGTH,    64, 1'b1, 63, 24'h00FF00},
        '{1'b0, REG_STRAND_LENGTH,   130, 1'b1,  2, 24'h0000FF},
        '{1'b0, REG_STRAND_LENGTH,   195, 1'b1, 60, 24'h7F7F00},
        '{1'b0, REG_STRAND_LENGTH,   260, 1'b1,  4, 24'h007F7F},
        '{1'b0, REG_STRAND_LENGTH,   325, 1'b1, 58, 24'h7F007F},
        '{1'b0, REG_STRAND_LENGTH, 65535, 1'b1,  0, 24'h7F7F00},
        '{1'b0, REG_STRAND_LENGTH,   384, 1'b1,  0, 24'hFF0000},
        '{1'b1, REG_MAX_LEVEL,         0, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,     1, 1'b1,  1, 24'h000000},
        '{1'b1, REG_MAX_LEVEL,         1, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,   200, 1'b1, 55, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,    65, 1'b1, 62, 24'h000100},
        '{1'b1, REG_STRAND_LENGTH,     1, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,     0, 1'b1,  0, 24'h010000},
        '{1'b0, REG_STRAND_LENGTH, 65535, 1'b1,  0, 24'h000000},
        '{1'b1, REG_STRAND_LENGTH,     0, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH, 12345, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,     0, 1'b0,  0, 24'h000000},
        '{1'b1, REG_STRAND_LENGTH,   127, 1'b0,  0, 24'h000000},
        '{1'b1, REG_MAX_LEVEL,       200, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,   100, 1'b1, 27, 24'h00C800},
        '{1'b0, REG_STRAND_LENGTH, 65535, 1'b1,  0, 24'h646400},
        '{1'b1, REG_STRAND_LENGTH,    65, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,    64, 1'b1, 63, 24'h00C800},
        '{1'b1, REG_STRAND_LENGTH,    63, 1'b0,  0, 24'h000000},
        '{1'b1, REG_MAX_LEVEL,       255, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,    62, 1'b1, 62, 24'hFF0000},
        '{1'b1, REG_STRAND_LENGTH,    64, 1'b0,  0, 24'h000000},
        '{1'b1, REG_MAX_LEVEL,       128, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH,     0, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH, 43690, 1'b0,  0, 24'h000000},
        '{1'b0, REG_STRAND_LENGTH, 21845, 1'b0,  0, 24'h000000}
    };

    led_chaser_fade_trail dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_valid  (step_valid),
        .step_stall  (step_stall),
        .step        (step),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel)
    );

    always #(CLK_HALF) clk = ~clk;

    // Advances the strand by one step word and queues the pixel words that
    // the sweep will emit. The step divided by the clamped length gives the
    // phase (quotient modulo six) and the lit position (remainder); odd
    // phases count the position from the far end. The lit pixel takes the
    // phase color and every other pixel in use drops to half on each channel.
    function automatic void advance_chaser(input logic [STEP_W-1:0] word);
        int unsigned        span;
        int unsigned        quot;
        int unsigned        lit;
        logic [PHASE_W-1:0] hue;
        logic [LEVEL_W-1:0] half_level;
        rgb_t               lamp;
        strand_word_t       out_word;
        if (strand_len == 0)
        begin
            return;
        end
        span = (strand_len > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : strand_len;
        quot = word / span;
        lit = word % span;
        hue = PHASE_W'(quot % NUM_PHASES);
        half_level = full_level >> 1;
        lamp = '0;
        case (hue)
            PH_RED:
            begin
                lamp.r = full_level;
            end
            PH_GREEN:
            begin
                lamp.g = full_level;
                lit = span - lit - 1;
            end
            PH_BLUE:
            begin
                lamp.b = full_level;
            end
            PH_YELLOW:
            begin
                lamp.r = half_level;
                lamp.g = half_level;
                lit = span - lit - 1;
            end
            PH_CYAN:
            begin
                lamp.g = half_level;
                lamp.b = half_level;
            end
            default:
            begin
                lamp.r = half_level;
                lamp.b = half_level;
                lit = span - lit - 1;
            end
        endcase
        for (int i = 0; i < span; i++)
        begin
            if (i == lit)
            begin
                strand_mem[i] = lamp;
            end
            else
            begin
                strand_mem[i].r = strand_mem[i].r >> 1;
                strand_mem[i].g = strand_mem[i].g >> 1;
                strand_mem[i].b = strand_mem[i].b >> 1;
            end
            out_word.idx = IDX_W'(i);
            out_word.color = strand_mem[i];
            out_word.last = (i + 1 == span);
            pixels_due.push_back(out_word);
        end
    endfunction

    // Writes one register and updates the testbench's copy. Called at a
    // falling edge; the task drops the enable and then waits for another
    // falling edge before it returns, so that back to back writes never drive
    // the enable twice in the same time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        if (sel == REG_STRAND_LENGTH)
        begin
            strand_len = data[LEN_W-1:0];
        end
        else
        begin
            full_level = data;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one step word from a falling edge and holds it until the block
    // takes it. The prediction is made at the accepting edge, long before the
    // first pixel word of that sweep can appear. Returns at the next falling
    // edge with valid still high.
    task automatic send_step(input logic [STEP_W-1:0] word);
        step <= word;
        step_valid <= 1'b1;
        @(posedge clk);
        while (step_stall)
        begin
            @(posedge clk);
        end
        advance_chaser(word);
        @(negedge clk);
    endtask

    // Random sender idling between words. Gaps run up to a little more than
    // a full sweep so that the next offer lands at every point of the
    // block's work: during the divide, mid sweep, or after it has gone idle.
    task automatic sender_gap();
        if (!steady_mode && $urandom_range(0, 99) < IDLE_PCT)
        begin
            step_valid <= 1'b0;
            repeat ($urandom_range(1, 100)) @(negedge clk);
        end
    endtask

    // Waits until every queued pixel word has come out, then lets a whole
    // sweep's worth of cycles pass in case a zero length step is still in
    // flight. Only after this may a register be written.
    task automatic settle();
        while (pixels_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver side. Stalls at random, except in the steady stretch, and
    // serves each hold-off request with a long stall of its own count. The
    // block then fills its output register and keeps its step input stalled.
    always @(negedge clk)
    begin
        if (holds_taken != holds_asked)
        begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pixel_stall <= 1'b1;
        end
        else if (steady_mode)
        begin
            pixel_stall <= 1'b0;
        end
        else
        begin
            pixel_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Checks every accepted pixel word against the oldest one still due.
    always @(posedge clk)
    begin
        strand_word_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("pixel word with none due: pixel_index %0d", pixel_index);
                mismatches++;
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pixel_index !== want.idx)
                begin
                    $error("pixel_index: expected %0d, got %0d", want.idx, pixel_index);
                    mismatches++;
                end
                if (red !== want.color.r)
                begin
                    $error("red: expected %0d, got %0d", want.color.r, red);
                    mismatches++;
                end
                if (green !== want.color.g)
                begin
                    $error("green: expected %0d, got %0d", want.color.g, green);
                    mismatches++;
                end
                if (blue !== want.color.b)
                begin
                    $error("blue: expected %0d, got %0d", want.color.b, blue);
                    mismatches++;
                end
                if (last_pixel !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. A correct run, even with every sweep at 64 pixels, every word
    // stalled and every sender gap at its longest, stays far below this.
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned        row_no;
        int unsigned        phase_no;
        int unsigned        item_no;
        int unsigned        span;
        plan_row_t          row;
        logic [STEP_W-1:0]  run_word;
        logic [CFG_W-1:0]   len_data;
        logic [CFG_W-1:0]   lvl_data;

        // State after reset: dark strand, 64 pixels, full level 255.
        strand_len = LEN_W'(MAX_PIXELS_DEF);
        full_level = '1;
        foreach (strand_mem[i])
        begin
            strand_mem[i] = '0;
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, one table row at a time. Register rows wait for the
        // block to go idle first.
        for (row_no = 0; row_no < PLAN_ROWS; row_no++)
        begin
            row = directed_plan[row_no];
            if (row.is_write)
            begin
                step_valid <= 1'b0;
                settle();
                write_reg(row.sel, row.value[CFG_W-1:0]);
            end
            else
            begin
                send_step(row.value[STEP_W-1:0]);
                if (row.typed)
                begin
                    // This sweep's words are the last ones queued.
                    span = (strand_len > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : strand_len;
                    pixels_due[pixels_due.size() - span + row.lit].color = row.color;
                end
                sender_gap();
            end
        end

        // Random part. Each phase runs under its own register setting. Most
        // words continue a run of consecutive steps, which is how a chaser is
        // driven and what builds up the fading trail and walks through the
        // phases; the rest jump to any 16-bit step.
        run_word = STEP_W'($urandom);
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            step_valid <= 1'b0;
            settle();
            case (phase_no)
                0:
                begin
                    len_data = CFG_W'(MAX_PIXELS_DEF);
                    lvl_data = '1;
                end
                1:
                begin
                    len_data = CFG_W'($urandom_range(1, 16));
                    lvl_data = CFG_W'($urandom);
                end
                2:
                begin
                    // Any byte at all, bit 7 included, as long as the length
                    // it carries is not zero.
                    do
                    begin
                        len_data = CFG_W'($urandom);
                    end
                    while (len_data[LEN_W-1:0] == 0);
                    lvl_data = CFG_W'($urandom);
                end
                3:
                begin
                    len_data = CFG_W'(1);
                    lvl_data = '0;
                end
                4:
                begin
                    len_data = CFG_W'(127);
                    lvl_data = CFG_W'($urandom);
                end
                default:
                begin
                    len_data = CFG_W'($urandom_range(1, 8));
                    lvl_data = CFG_W'($urandom);
                end
            endcase
            write_reg(REG_STRAND_LENGTH, len_data);
            write_reg(REG_MAX_LEVEL, lvl_data);

            // The first phase runs with no idling on either side.
            steady_mode = (phase_no == 0);
            if (phase_no == 1)
            begin
                holds_asked++;
            end

            for (item_no = 0; item_no < WORDS_PER_PHASE; item_no++)
            begin
                if ($urandom_range(0, 99) < RUN_PCT)
                begin
                    run_word = run_word + 1'b1;
                end
                else
                begin
                    run_word = STEP_W'($urandom);
                end
                send_step(run_word);
                if (phase_no == 2 && item_no == WORDS_PER_PHASE / 2)
                begin
                    // Sender pause: nothing more is offered until the block
                    // has emitted every word due.
                    step_valid <= 1'b0;
                    while (pixels_due.size() != 0)
                    begin
                        @(negedge clk);
                    end
                    @(negedge clk);
                end
                else
                begin
                    sender_gap();
                end
            end
        end

        step_valid <= 1'b0;
        steady_mode = 1'b0;
        settle();

        if (mismatches == 0 && pixels_due.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* led_chaser_fade_trail.f */
design/lcft_pkg.sv
design/lcft_divider.sv
design/lcft_store.sv
design/led_chaser_fade_trail.sv
tb/sv/tb_top.sv
